// ===== sv/srtf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int MAX_PROCS = 64;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int PIDX_W    = 6;
    localparam int TIME_W    = 16;
    localparam int TICK_W    = 32;
    localparam int SUM_W     = 32;
    localparam int IN_DATA_W = 40;

    typedef struct packed {
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remain;
        logic [TIME_W-1:0] arrival;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ===== sv/srtf_total_waiting_time_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports            Contents
// s (in)    input      i_s_t*, o_s_t*   one process item, tlast marks the final one
// m (out)   output     o_m_t*, i_m_t*   total waiting time of the batch
//
// Loading accepts an item whenever the unit is idle.
// After the final item, each scheduling event costs one scan of the table,
// whether a process runs or time skips to the next arrival; the table's
// single read port paces the scan.
// Reset is synchronous and clears the control state only; table contents persist.
// The result sits in an output register; a finished run waits only if the
// previous result has not been taken yet.

module srtf_total_waiting_time_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // proc_index[5:0], arrival_time[21:6], burst_time[37:22], zero fill[39:38]
    input  wire logic [39:0] i_s_tdata,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // total_wait[31:0]
    output logic      [31:0] o_m_tdata,
    // wait_saturated[0]
    output logic             o_m_tuser
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_WCALC  = 3'd3;
    localparam logic [2:0] S_ACC    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam int IW = srtf_pkg::IDX_W;
    localparam int CW = srtf_pkg::CNT_W;
    localparam int TW = srtf_pkg::TIME_W;
    localparam int KW = srtf_pkg::TICK_W;
    localparam int SW = srtf_pkg::SUM_W;

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_addr;
    logic          r_issued_all;
    logic          r_rd_vld;
    logic          r_rd_last;
    logic [IW-1:0] r_rd_idx;
    logic [KW-1:0] r_tick;
    logic [SW-1:0] r_acc;
    logic          r_sat;
    logic          r_have_best;
    logic          r_have_next;
    logic [IW-1:0] r_best_idx;
    logic [TW-1:0] r_best_rem;
    logic [TW-1:0] r_best_arr;
    logic [TW-1:0] r_best_bur;
    logic [TW-1:0] r_next_arr;
    logic          r_fin;
    logic [SW-1:0] r_wait;
    logic          r_out_vld;
    logic [SW-1:0] r_out_sum;
    logic          r_out_sat;

    logic [srtf_pkg::PIDX_W-1:0] w_in_idx;
    logic [TW-1:0]               w_in_arr;
    logic [TW-1:0]               w_in_bur;
    logic                        w_accept;
    logic                        w_issue;
    logic                        w_issue_last;
    logic                        w_out_load;
    logic [TW-1:0]               w_diff;
    logic [TW-1:0]               w_run;
    logic [TW-1:0]               n_rem;
    logic [SW:0]                 w_sum;
    logic                        w_ram_we;
    logic [IW-1:0]               w_ram_waddr;
    srtf_pkg::t_entry            w_ram_wdata;
    srtf_pkg::t_entry            w_rd;

    assign w_in_idx = i_s_tdata[5:0];
    assign w_in_arr = i_s_tdata[21:6];
    assign w_in_bur = i_s_tdata[37:22];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_issue      = (r_state == S_SCAN) && !r_issued_all;
    assign w_issue_last = (r_addr == IW'(r_count - CW'(1)));
    assign w_out_load   = (r_state == S_DONE) && (!r_out_vld || i_m_tready);

    assign w_diff = r_next_arr - r_tick[TW-1:0];
    assign w_run  = (r_have_next && (w_diff < r_best_rem)) ? w_diff : r_best_rem;
    assign n_rem  = r_best_rem - w_run;
    assign w_sum  = {1'b0, r_acc} + {1'b0, r_wait};

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_best_idx;
        w_ram_wdata = '{burst: r_best_bur, remain: n_rem, arrival: r_best_arr};
        if (r_state == S_IDLE) begin
            w_ram_we    = w_accept && (int'(w_in_idx) < srtf_pkg::MAX_PROCS);
            w_ram_waddr = IW'(w_in_idx);
            w_ram_wdata = '{burst: w_in_bur, remain: w_in_bur, arrival: w_in_arr};
        end else if (r_state == S_DECIDE) begin
            w_ram_we = r_have_best;
        end
    end

    srtf_ram #(
        .WIDTH (srtf_pkg::ENTRY_W),
        .DEPTH (srtf_pkg::MAX_PROCS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_addr       <= '0;
            r_issued_all <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_last    <= 1'b0;
            r_tick       <= '0;
            r_acc        <= '0;
            r_sat        <= 1'b0;
            r_have_best  <= 1'b0;
            r_have_next  <= 1'b0;
            r_fin        <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_rd_vld  <= w_issue;
            r_rd_last <= w_issue && w_issue_last;
            if (w_issue) begin
                r_addr <= r_addr + IW'(1);
                if (w_issue_last) begin
                    r_issued_all <= 1'b1;
                end
            end

            if (r_rd_vld && (w_rd.remain != '0)) begin
                if (KW'(w_rd.arrival) <= r_tick) begin
                    if (!r_have_best || (w_rd.remain < r_best_rem)) begin
                        r_have_best <= 1'b1;
                    end
                end else if (!r_have_next || (w_rd.arrival < r_next_arr)) begin
                    r_have_next <= 1'b1;
                end
            end

            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_count < CW'(srtf_pkg::MAX_PROCS)) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (i_s_tlast) begin
                            r_tick       <= '0;
                            r_acc        <= '0;
                            r_sat        <= 1'b0;
                            r_addr       <= '0;
                            r_issued_all <= 1'b0;
                            r_have_best  <= 1'b0;
                            r_have_next  <= 1'b0;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rd_vld && r_rd_last) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_have_best) begin
                        r_tick  <= r_tick + KW'(w_run);
                        r_fin   <= (n_rem == '0);
                        r_state <= S_WCALC;
                    end else if (r_have_next) begin
                        r_tick       <= KW'(r_next_arr);
                        r_addr       <= '0;
                        r_issued_all <= 1'b0;
                        r_have_best  <= 1'b0;
                        r_have_next  <= 1'b0;
                        r_state      <= S_SCAN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_WCALC: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_fin) begin
                        if (w_sum[SW]) begin
                            r_acc <= '1;
                            r_sat <= 1'b1;
                        end else begin
                            r_acc <= w_sum[SW-1:0];
                        end
                    end
                    r_addr       <= '0;
                    r_issued_all <= 1'b0;
                    r_have_best  <= 1'b0;
                    r_have_next  <= 1'b0;
                    r_state      <= S_SCAN;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_count <= '0;
                        r_tick  <= '0;
                        r_acc   <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (r_rd_vld && (w_rd.remain != '0)) begin
            if (KW'(w_rd.arrival) <= r_tick) begin
                if (!r_have_best || (w_rd.remain < r_best_rem)) begin
                    r_best_idx <= r_rd_idx;
                    r_best_rem <= w_rd.remain;
                    r_best_arr <= w_rd.arrival;
                    r_best_bur <= w_rd.burst;
                end
            end else if (!r_have_next || (w_rd.arrival < r_next_arr)) begin
                r_next_arr <= w_rd.arrival;
            end
        end
        if (r_state == S_WCALC) begin
            r_wait <= r_tick - SW'(r_best_arr) - SW'(r_best_bur);
        end
        if (w_out_load) begin
            r_out_sum <= r_acc;
            r_out_sat <= r_sat;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_sum;
    assign o_m_tuser  = r_out_sat;

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && !r_issued_all) |-> (CW'(r_addr) < r_count))
        else $error("scan address beyond loaded processes");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(srtf_pkg::MAX_PROCS))
        else $error("load count exceeds table depth");

    a_best_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_have_best) |-> (r_best_rem != '0))
        else $error("chosen process has no remaining time");

    a_next_future: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_have_next) |-> (KW'(r_next_arr) > r_tick))
        else $error("next arrival is not in the future");

    a_acc_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |=> (r_acc >= $past(r_acc)))
        else $error("waiting time sum decreased");

endmodule

`default_nettype wire

// ===== sv/srtf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
